// ----- hw/rtl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants for the structured sparsity column checker.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int unsigned COLUMN_W = 12;
    localparam int unsigned LIMIT_W  = 8;

    localparam logic [1:0] MODE_CHECK  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [COLUMN_W-1:0] column;
        logic                last;
    } t_item;

    typedef struct packed {
        logic fits;
        logic saturated;
    } t_result;

endpackage

// ----- hw/rtl/ssc_ram.sv -----
// ----------------------------------------------------------------------------
// ssc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/structured_sparsity_column_checker_core.sv -----
// ----------------------------------------------------------------------------
// structured_sparsity_column_checker_core
// Per-column row counters in one RAM; checks, adds or clears sparse rows.
//
//  port group      dir  handshake            payload
//  item            in   start & !busy        i_item   (ssc_pkg::t_item)
//  result          out  o_done, 1 cycle      o_result (ssc_pkg::t_result)
//  limit register  in   i_cfg_we             i_cfg_wdata
//
//  One beat per cycle while busy is low; the counter read-modify-write takes two stages
//  (RAM read, then compare/increment and write back) with forwarding.
//  o_done is registered and rises in the cycle after the last beat of a row is in stage 1.
//  After reset and after every clear beat, a clearing pass zeroes the RAM;
//  busy stays high during it.
//  The receiver cannot stall: o_done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module structured_sparsity_column_checker_core #(
    parameter int unsigned COLUMNS    = 4096,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  ssc_pkg::t_item                        i_item,
    output logic                                  o_done,
    output ssc_pkg::t_result                      o_result,
    input  logic                                  i_cfg_we,
    input  logic [ssc_pkg::LIMIT_W-1:0]           i_cfg_wdata
);

    localparam int unsigned AW   = $clog2(COLUMNS);
    localparam int unsigned XW   = ssc_pkg::COLUMN_W + AW;
    localparam int unsigned CMPW = (COUNT_BITS > ssc_pkg::LIMIT_W) ?
                                   COUNT_BITS : ssc_pkg::LIMIT_W;

    logic                          accept;
    logic [XW-1:0]                 col_ext;
    logic [AW-1:0]                 rd_addr;
    logic                          in_range;

    logic                          r_clearing;
    logic [AW-1:0]                 r_sweep;
    logic [ssc_pkg::LIMIT_W-1:0]   r_limit;

    logic                          r_s1_valid;
    logic [1:0]                    r_s1_mode;
    logic                          r_s1_last;
    logic                          r_s1_in_range;
    logic [AW-1:0]                 r_s1_addr;

    logic                          r_fwd_valid;
    logic [COUNT_BITS-1:0]         r_fwd_data;

    logic                          r_row_failed;
    logic                          r_row_sat;
    logic                          n_row_failed;
    logic                          n_row_sat;

    logic                          r_done;
    ssc_pkg::t_result              r_result;
    ssc_pkg::t_result              n_result;

    logic [COUNT_BITS-1:0]         ram_rdata;
    logic [COUNT_BITS-1:0]         cnt;
    logic [COUNT_BITS-1:0]         new_cnt;
    logic                          full;
    logic                          sat_hit;
    logic                          s1_check;
    logic                          s1_update;
    logic                          s1_we;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [COUNT_BITS-1:0]         ram_wdata;

    assign busy     = r_clearing;
    assign accept   = start && !busy;
    assign col_ext  = XW'(i_item.column);
    assign rd_addr  = col_ext[AW-1:0];
    assign in_range = ({1'b0, col_ext} < (XW+1)'(COLUMNS));

    // stage 1: counter compare and increment
    assign cnt       = r_fwd_valid ? r_fwd_data : ram_rdata;
    assign new_cnt   = cnt + 1'b1;
    assign full      = r_s1_in_range && (CMPW'(cnt) >= CMPW'(r_limit));
    assign sat_hit   = r_s1_in_range && (cnt == {COUNT_BITS{1'b1}});
    assign s1_check  = r_s1_valid && (r_s1_mode == ssc_pkg::MODE_CHECK);
    assign s1_update = r_s1_valid && (r_s1_mode == ssc_pkg::MODE_UPDATE);
    assign s1_we     = s1_update && r_s1_in_range && !sat_hit;

    assign ram_we    = r_clearing || s1_we;
    assign ram_waddr = r_clearing ? r_sweep : r_s1_addr;
    assign ram_wdata = r_clearing ? '0 : new_cnt;

    always_comb begin
        n_row_failed = r_row_failed || (s1_check && full);
        n_row_sat    = r_row_sat || (s1_update && sat_hit);
        n_result.fits      = s1_check ? !n_row_failed : 1'b1;
        n_result.saturated = s1_update ? n_row_sat : 1'b0;
    end

    ssc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (COLUMNS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_sweep      <= '0;
            r_limit      <= ssc_pkg::LIMIT_RESET;
            r_s1_valid   <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_row_failed <= 1'b0;
            r_row_sat    <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end

            if (r_clearing) begin
                r_sweep <= r_sweep + 1'b1;
                if (r_sweep == AW'(COLUMNS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end else if (accept && (i_item.mode == ssc_pkg::MODE_CLEAR)) begin
                r_clearing <= 1'b1;
                r_sweep    <= '0;
            end

            r_s1_valid  <= accept && (i_item.mode != ssc_pkg::MODE_RSVD);
            r_fwd_valid <= accept && s1_we && (rd_addr == r_s1_addr);

            if (r_s1_valid) begin
                if (r_s1_mode == ssc_pkg::MODE_CLEAR || r_s1_last) begin
                    r_row_failed <= 1'b0;
                    r_row_sat    <= 1'b0;
                end else begin
                    r_row_failed <= n_row_failed;
                    r_row_sat    <= n_row_sat;
                end
            end

            r_done <= r_s1_valid && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode     <= i_item.mode;
            r_s1_last     <= i_item.last;
            r_s1_in_range <= in_range;
            r_s1_addr     <= rd_addr;
        end
        r_fwd_data <= new_cnt;
        r_result   <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // a row beat never writes the RAM while the clearing pass owns it
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clearing && s1_we))
        else $error("row write during clearing pass");

    // forwarded data only follows a counter write in the previous cycle
    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> $past(s1_we))
        else $error("forward without preceding write");

    // a failed check and a saturated update never share one result
    a_result_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.fits || !o_result.saturated))
        else $error("result both failed and saturated");

    // a clear beat starts the clearing pass on the next cycle
    a_clear_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.mode == ssc_pkg::MODE_CLEAR) |=> busy)
        else $error("clear beat did not start clearing pass");

endmodule
